// ===== rtl/tgv_pkg.sv =====
// ----------------------------------------------------------------------------
// tgv_pkg
// Shared widths, beat structs and the quarter-wave sine table builder for the
// torus grid vertex generator.
// ----------------------------------------------------------------------------
package tgv_pkg;

  localparam int DEPTH    = 1024;
  localparam int DEPTH_LOG2 = $clog2(DEPTH);
  localparam int MAX_SEG  = 1024;
  localparam int STEP_W   = 11;
  localparam int SEG_W    = 11;
  localparam int RAD_W    = 16;
  localparam int PH_W     = $clog2(4 * DEPTH);
  localparam int ADDR_W   = $clog2(DEPTH + 1);
  localparam int Q_W      = 15;
  localparam int TRIG_W   = 16;
  localparam int NUM_W    = STEP_W + PH_W + 1;
  localparam int DIV_W    = $clog2(2 * MAX_SEG) + 1;
  localparam int REM_W    = DIV_W - 1;
  localparam int IDX_W    = 21;
  localparam int PX_W     = 18;
  localparam int PZ_W     = 17;
  localparam int NRM_W    = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MAJOR_RADIUS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINOR_RADIUS   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAJOR_SEGMENTS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MINOR_SEGMENTS = 8'd3;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // ceil(2^42 / ((2n)(2n+1))): exact truncating quotient for dividends below 2^33
  localparam int RECIP_SH = 42;
  localparam longint unsigned TAYLOR_RECIP [1:8] = '{
    ((64'd1 << RECIP_SH) + 64'd5) / 64'd6,
    ((64'd1 << RECIP_SH) + 64'd19) / 64'd20,
    ((64'd1 << RECIP_SH) + 64'd41) / 64'd42,
    ((64'd1 << RECIP_SH) + 64'd71) / 64'd72,
    ((64'd1 << RECIP_SH) + 64'd109) / 64'd110,
    ((64'd1 << RECIP_SH) + 64'd155) / 64'd156,
    ((64'd1 << RECIP_SH) + 64'd209) / 64'd210,
    ((64'd1 << RECIP_SH) + 64'd271) / 64'd272
  };

  typedef struct packed {
    logic [IDX_W-1:0] vi;
    logic [IDX_W-1:0] ni;
    logic             quad;
    logic             oor;
  } side_t;

  typedef struct packed {
    logic signed [PX_W-1:0]  px;
    logic signed [PX_W-1:0]  py;
    logic signed [PZ_W-1:0]  pz;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } res_t;

  typedef logic [Q_W-1:0] qtab_t [0:DEPTH];

  function automatic qtab_t build_qtab();
    qtab_t             tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    logic [127:0]      prod;
    longint            sum;
    longint            r;
    for (int k = 0; k <= DEPTH; k++) begin
      x = (longint'(k) * HALF_PI_Q30 * 2 + DEPTH) >> (DEPTH_LOG2 + 1);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        prod = 128'((term * x2) >> 30) * 128'(TAYLOR_RECIP[n]);
        term = 64'(prod >> RECIP_SH);
        if ((n & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 32768) >>> 16;
      if (r > 16384) begin
        r = 16384;
      end
      tab[k] = Q_W'(r);
    end
    return tab;
  endfunction

endpackage

// ===== rtl/tgv_phase.sv =====
// ----------------------------------------------------------------------------
// tgv_phase
// Input stage and bit-serial pipelined dividers that turn ring and tube steps
// into table phases, plus the vertex index arithmetic.
// ----------------------------------------------------------------------------
module tgv_phase (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [tgv_pkg::STEP_W-1:0]   ring_step,
  input  logic [tgv_pkg::STEP_W-1:0]   tube_step,
  input  logic [tgv_pkg::SEG_W-1:0]    major_segments,
  input  logic [tgv_pkg::SEG_W-1:0]    minor_segments,
  output logic                         out_valid,
  output logic [tgv_pkg::PH_W-1:0]     phase_t,
  output logic [tgv_pkg::PH_W-1:0]     phase_p,
  output tgv_pkg::side_t               side
);

  localparam int NS = tgv_pkg::NUM_W;

  logic [tgv_pkg::SEG_W-1:0] nm;
  logic [tgv_pkg::SEG_W-1:0] nn;
  logic [tgv_pkg::SEG_W-1:0] nn1;
  logic [tgv_pkg::IDX_W:0]   vi_full;
  logic [tgv_pkg::IDX_W:0]   ni_full;

  logic                         vld   [0:NS];
  logic [tgv_pkg::NUM_W-1:0]    num_t [0:NS];
  logic [tgv_pkg::NUM_W-1:0]    num_p [0:NS];
  logic [tgv_pkg::DIV_W-1:0]    d_t   [0:NS];
  logic [tgv_pkg::DIV_W-1:0]    d_p   [0:NS];
  logic [tgv_pkg::REM_W-1:0]    rem_t [0:NS];
  logic [tgv_pkg::REM_W-1:0]    rem_p [0:NS];
  logic [tgv_pkg::PH_W-1:0]     q_t   [0:NS];
  logic [tgv_pkg::PH_W-1:0]     q_p   [0:NS];
  tgv_pkg::side_t               sd    [0:NS];

  always_comb begin
    if (major_segments == '0) begin
      nm = tgv_pkg::SEG_W'(1);
    end else if (major_segments > tgv_pkg::SEG_W'(tgv_pkg::MAX_SEG)) begin
      nm = tgv_pkg::SEG_W'(tgv_pkg::MAX_SEG);
    end else begin
      nm = major_segments;
    end
    if (minor_segments == '0) begin
      nn = tgv_pkg::SEG_W'(1);
    end else if (minor_segments > tgv_pkg::SEG_W'(tgv_pkg::MAX_SEG)) begin
      nn = tgv_pkg::SEG_W'(tgv_pkg::MAX_SEG);
    end else begin
      nn = minor_segments;
    end
    nn1 = nn + tgv_pkg::SEG_W'(1);
    vi_full = (tgv_pkg::IDX_W+1)'(ring_step * nn1) + (tgv_pkg::IDX_W+1)'(tube_step);
    ni_full = (tgv_pkg::IDX_W+1)'((ring_step + tgv_pkg::STEP_W'(1)) * nn1)
            + (tgv_pkg::IDX_W+1)'(tube_step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_t[0] <= {ring_step, (tgv_pkg::PH_W+1)'(0)} + tgv_pkg::NUM_W'(nm);
      num_p[0] <= {tube_step, (tgv_pkg::PH_W+1)'(0)} + tgv_pkg::NUM_W'(nn);
      d_t[0]   <= {nm, 1'b0};
      d_p[0]   <= {nn, 1'b0};
      rem_t[0] <= '0;
      rem_p[0] <= '0;
      q_t[0]   <= '0;
      q_p[0]   <= '0;
      sd[0].vi   <= vi_full[tgv_pkg::IDX_W-1:0];
      sd[0].ni   <= ni_full[tgv_pkg::IDX_W-1:0];
      sd[0].quad <= (ring_step < nm) && (tube_step < nn);
      sd[0].oor  <= (ring_step > nm) || (tube_step > nn);
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [tgv_pkg::DIV_W-1:0] tt;
    logic [tgv_pkg::DIV_W-1:0] tp;
    logic                      ge_t;
    logic                      ge_p;

    assign tt   = {rem_t[k], num_t[k][tgv_pkg::NUM_W-1]};
    assign tp   = {rem_p[k], num_p[k][tgv_pkg::NUM_W-1]};
    assign ge_t = tt >= d_t[k];
    assign ge_p = tp >= d_p[k];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_t[k+1] <= num_t[k] << 1;
        num_p[k+1] <= num_p[k] << 1;
        d_t[k+1]   <= d_t[k];
        d_p[k+1]   <= d_p[k];
        rem_t[k+1] <= ge_t ? tgv_pkg::REM_W'(tt - d_t[k]) : tgv_pkg::REM_W'(tt);
        rem_p[k+1] <= ge_p ? tgv_pkg::REM_W'(tp - d_p[k]) : tgv_pkg::REM_W'(tp);
        q_t[k+1]   <= {q_t[k][tgv_pkg::PH_W-2:0], ge_t};
        q_p[k+1]   <= {q_p[k][tgv_pkg::PH_W-2:0], ge_p};
        sd[k+1]    <= sd[k];
      end
    end
  end

  assign out_valid = vld[NS];
  assign phase_t   = q_t[NS];
  assign phase_p   = q_p[NS];
  assign side      = sd[NS];

endmodule

// ===== rtl/tgv_sine_rom.sv =====
// ----------------------------------------------------------------------------
// tgv_sine_rom
// Quarter-wave sine table, Q1.14, two registered read ports.
// ----------------------------------------------------------------------------
module tgv_sine_rom (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tgv_pkg::ADDR_W-1:0] addr_a,
  input  logic [tgv_pkg::ADDR_W-1:0] addr_b,
  output logic [tgv_pkg::Q_W-1:0]    q_a,
  output logic [tgv_pkg::Q_W-1:0]    q_b
);

  localparam tgv_pkg::qtab_t ROM = tgv_pkg::build_qtab();

  always_ff @(posedge clk) begin
    if (en) begin
      q_a <= ROM[addr_a];
      q_b <= ROM[addr_b];
    end
  end

endmodule

// ===== rtl/tgv_geom.sv =====
// ----------------------------------------------------------------------------
// tgv_geom
// Sine and cosine lookup, then position and normal arithmetic in fixed point.
// ----------------------------------------------------------------------------
module tgv_geom (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [tgv_pkg::PH_W-1:0]   phase_t,
  input  logic [tgv_pkg::PH_W-1:0]   phase_p,
  input  tgv_pkg::side_t             in_side,
  input  logic [tgv_pkg::RAD_W-1:0]  major_radius,
  input  logic [tgv_pkg::RAD_W-1:0]  minor_radius,
  output logic                       out_valid,
  output tgv_pkg::res_t              res,
  output tgv_pkg::side_t             out_side
);

  localparam int NSTG = 7;
  localparam int PW   = tgv_pkg::RAD_W + tgv_pkg::TRIG_W + 1;
  localparam int RW   = PW + 2;
  localparam int XW   = RW + tgv_pkg::TRIG_W;

  logic           vld [0:NSTG-1];
  tgv_pkg::side_t sd  [0:NSTG-1];

  logic [tgv_pkg::PH_W-1:0] ph_ct;
  logic [tgv_pkg::PH_W-1:0] ph_cp;

  logic [tgv_pkg::ADDR_W-1:0] a_st, a_ct, a_sp, a_cp;
  logic [3:0]                 neg1, neg2;
  logic [tgv_pkg::Q_W-1:0]    e_st, e_ct, e_sp, e_cp;

  logic signed [tgv_pkg::TRIG_W-1:0] st, ct, sp, cp;
  logic signed [tgv_pkg::TRIG_W-1:0] st4, ct4, sp4;
  logic signed [PW-1:0]              mr, pzp, nxp, nyp;
  logic signed [tgv_pkg::TRIG_W-1:0] st5, ct5, sp5;
  logic signed [RW-1:0]              ring;
  logic signed [tgv_pkg::PZ_W-1:0]   pz5;
  logic signed [tgv_pkg::NRM_W-1:0]  nx5, ny5;
  logic signed [tgv_pkg::TRIG_W-1:0] sp6;
  logic signed [XW-1:0]              xp, yp;
  logic signed [tgv_pkg::PZ_W-1:0]   pz6;
  logic signed [tgv_pkg::NRM_W-1:0]  nx6, ny6;

  logic signed [PW-1:0] pz_r, nx_r, ny_r;
  logic signed [XW-1:0] x_r, y_r;

  function automatic logic [tgv_pkg::ADDR_W-1:0] qaddr(input logic [tgv_pkg::PH_W-1:0] p);
    logic [tgv_pkg::ADDR_W-1:0] o;
    o = tgv_pkg::ADDR_W'(p[tgv_pkg::PH_W-3:0]);
    return p[tgv_pkg::PH_W-2] ? tgv_pkg::ADDR_W'(tgv_pkg::DEPTH) - o : o;
  endfunction

  function automatic logic signed [tgv_pkg::PX_W-1:0] sat_x(input logic signed [XW-1:0] v);
    logic signed [XW-29:0] s;
    s = (XW-28)'(v >>> 28);
    if (s > (XW-28)'(131071)) begin
      return tgv_pkg::PX_W'(131071);
    end else if (s < -(XW-28)'(131072)) begin
      return tgv_pkg::PX_W'(-131072);
    end
    return tgv_pkg::PX_W'(s);
  endfunction

  assign ph_ct = phase_t + tgv_pkg::PH_W'(tgv_pkg::DEPTH);
  assign ph_cp = phase_p + tgv_pkg::PH_W'(tgv_pkg::DEPTH);

  for (genvar k = 0; k < NSTG; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sd[k] <= (k == 0) ? in_side : sd[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_st <= qaddr(phase_t);
      a_ct <= qaddr(ph_ct);
      a_sp <= qaddr(phase_p);
      a_cp <= qaddr(ph_cp);
      neg1 <= {phase_t[tgv_pkg::PH_W-1], ph_ct[tgv_pkg::PH_W-1],
               phase_p[tgv_pkg::PH_W-1], ph_cp[tgv_pkg::PH_W-1]};
      neg2 <= neg1;
    end
  end

  tgv_sine_rom u_rom_t (
    .clk    (clk),
    .en     (en),
    .addr_a (a_st),
    .addr_b (a_ct),
    .q_a    (e_st),
    .q_b    (e_ct)
  );

  tgv_sine_rom u_rom_p (
    .clk    (clk),
    .en     (en),
    .addr_a (a_sp),
    .addr_b (a_cp),
    .q_a    (e_sp),
    .q_b    (e_cp)
  );

  assign pz_r = pzp + PW'(8192);
  assign nx_r = nxp + PW'(8192);
  assign ny_r = nyp + PW'(8192);
  assign x_r  = xp + (XW'(1) <<< 27);
  assign y_r  = yp + (XW'(1) <<< 27);

  always_ff @(posedge clk) begin
    if (en) begin
      st <= neg2[3] ? -$signed({1'b0, e_st}) : $signed({1'b0, e_st});
      ct <= neg2[2] ? -$signed({1'b0, e_ct}) : $signed({1'b0, e_ct});
      sp <= neg2[1] ? -$signed({1'b0, e_sp}) : $signed({1'b0, e_sp});
      cp <= neg2[0] ? -$signed({1'b0, e_cp}) : $signed({1'b0, e_cp});

      mr  <= PW'($signed({1'b0, minor_radius}) * cp);
      pzp <= PW'($signed({1'b0, minor_radius}) * sp);
      nxp <= PW'(cp * ct);
      nyp <= PW'(cp * st);
      st4 <= st;
      ct4 <= ct;
      sp4 <= sp;

      ring <= $signed(RW'({major_radius, 14'd0})) + RW'(mr);
      pz5  <= tgv_pkg::PZ_W'(pz_r >>> 14);
      nx5  <= tgv_pkg::NRM_W'(nx_r >>> 14);
      ny5  <= tgv_pkg::NRM_W'(ny_r >>> 14);
      st5  <= st4;
      ct5  <= ct4;
      sp5  <= sp4;

      xp  <= XW'(ring * ct5);
      yp  <= XW'(ring * st5);
      pz6 <= pz5;
      nx6 <= nx5;
      ny6 <= ny5;
      sp6 <= sp5;

      res.px <= sat_x(x_r);
      res.py <= sat_x(y_r);
      res.pz <= pz6;
      res.nx <= nx6;
      res.ny <= ny6;
      res.nz <= sp6;
    end
  end

  assign out_valid = vld[NSTG-1];
  assign out_side  = sd[NSTG-1];

endmodule

// ===== rtl/torus_grid_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// torus_grid_vertex_generator
// Torus mesh vertex generator: position, unit normal and quad indices per
// grid point.
// ----------------------------------------------------------------------------
// One grid point is accepted every clock cycle unless the master side stalls;
// its vertex passes through one input stage, 24 stages of the bit-serial
// step-to-phase dividers, seven stages of table lookup and multiply, and the
// output register. Back-pressure on the master side stalls the whole pipeline
// in place. The configuration channel is always ready; write it only while no
// point is in flight.
module torus_grid_vertex_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,   // ring_step, tube_step
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [143:0]                    m_tdata,   // pos_x, pos_y, pos_z, norm_x,
                                                     // norm_y, norm_z, vertex_index,
                                                     // next_ring_index
  output logic [1:0]                      m_tuser,   // quad_valid, out_of_range
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tgv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tgv_pkg::RAD_W-1:0]       cfg_data
);

  logic [tgv_pkg::RAD_W-1:0] major_radius;
  logic [tgv_pkg::RAD_W-1:0] minor_radius;
  logic [tgv_pkg::SEG_W-1:0] major_segments;
  logic [tgv_pkg::SEG_W-1:0] minor_segments;

  logic                     en;
  logic                     ph_valid;
  logic [tgv_pkg::PH_W-1:0] phase_t;
  logic [tgv_pkg::PH_W-1:0] phase_p;
  tgv_pkg::side_t           ph_side;
  logic                     g_valid;
  tgv_pkg::res_t            g_res;
  tgv_pkg::side_t           g_side;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      major_radius   <= tgv_pkg::RAD_W'(256);
      minor_radius   <= tgv_pkg::RAD_W'(64);
      major_segments <= tgv_pkg::SEG_W'(32);
      minor_segments <= tgv_pkg::SEG_W'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        tgv_pkg::REG_MAJOR_RADIUS:   major_radius   <= cfg_data;
        tgv_pkg::REG_MINOR_RADIUS:   minor_radius   <= cfg_data;
        tgv_pkg::REG_MAJOR_SEGMENTS: major_segments <= cfg_data[tgv_pkg::SEG_W-1:0];
        tgv_pkg::REG_MINOR_SEGMENTS: minor_segments <= cfg_data[tgv_pkg::SEG_W-1:0];
        default: ;
      endcase
    end
  end

  tgv_phase u_phase (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (s_tvalid),
    .ring_step      (s_tdata[10:0]),
    .tube_step      (s_tdata[21:11]),
    .major_segments (major_segments),
    .minor_segments (minor_segments),
    .out_valid      (ph_valid),
    .phase_t        (phase_t),
    .phase_p        (phase_p),
    .side           (ph_side)
  );

  tgv_geom u_geom (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (ph_valid),
    .phase_t      (phase_t),
    .phase_p      (phase_p),
    .in_side      (ph_side),
    .major_radius (major_radius),
    .minor_radius (minor_radius),
    .out_valid    (g_valid),
    .res          (g_res),
    .out_side     (g_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, g_side.ni, g_side.vi, g_res.nz, g_res.ny, g_res.nx,
                  g_res.pz, g_res.py, g_res.px};
      m_tuser <= {g_side.oor, g_side.quad};
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the torus grid vertex generator. Grid points are streamed in
// under several register settings, including the clamped segment counts and
// the largest radii. Each vertex is predicted in the bench and compared field
// by field. Sender and receiver idle at random, and the receiver also holds
// off long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [tgv_pkg::PX_W-1:0]  px;
    logic signed [tgv_pkg::PX_W-1:0]  py;
    logic signed [tgv_pkg::PZ_W-1:0]  pz;
    logic signed [tgv_pkg::NRM_W-1:0] nx;
    logic signed [tgv_pkg::NRM_W-1:0] ny;
    logic signed [tgv_pkg::NRM_W-1:0] nz;
    logic [tgv_pkg::IDX_W-1:0]        vi;
    logic [tgv_pkg::IDX_W-1:0]        ni;
    logic                             quad;
    logic                             oor;
  } vertex_t;

  localparam int FULL_TURN  = 4 * tgv_pkg::DEPTH;
  localparam int IDLE_LIMIT = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [23:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [tgv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tgv_pkg::RAD_W-1:0]     cfg_data = '0;
  logic         rx_hold = 1'b0;

  int unsigned  major_r, minor_r, major_n, minor_n;
  int           sine_q [0:tgv_pkg::DEPTH];
  vertex_t      vertex_q [$];
  int           tx_idle_pct, rx_idle_pct;
  int           fail_count, vertices_seen, points_sent, idle_count;

  torus_grid_vertex_generator dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int quarter_sine(int k);
    longint unsigned ang, ang2, t;
    longint          acc, q;
    ang = (longint'(k) * tgv_pkg::HALF_PI_Q30 * 2 + tgv_pkg::DEPTH) / (2 * tgv_pkg::DEPTH);
    ang2 = (ang * ang) >> 30;
    t = ang;
    acc = longint'(ang);
    for (int n = 1; n <= 8; n++) begin
      t = ((t * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
      acc = (n & 1) ? acc - longint'(t) : acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    q = (acc + 32768) >> 16;
    return (q > 16384) ? 16384 : int'(q);
  endfunction

  function automatic longint sine_at(int p);
    int o;
    o = p % tgv_pkg::DEPTH;
    case ((p / tgv_pkg::DEPTH) & 3)
      0: return sine_q[o];
      1: return sine_q[tgv_pkg::DEPTH - o];
      2: return -sine_q[o];
      default: return -sine_q[tgv_pkg::DEPTH - o];
    endcase
  endfunction

  function automatic int step_phase(int step, int segs);
    longint p;
    p = (longint'(step) * FULL_TURN * 2 + segs) / (2 * longint'(segs));
    return int'(p % FULL_TURN);
  endfunction

  function automatic int clamp_segs(int s);
    return (s < 1) ? 1 : (s > tgv_pkg::MAX_SEG ? tgv_pkg::MAX_SEG : s);
  endfunction

  function automatic longint round_q(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic vertex_t predict_vertex(int i, int j);
    vertex_t v;
    int      nm, nn, pt, pp;
    longint  st, ct, sp, cp, ring, idx;
    nm = clamp_segs(major_n);
    nn = clamp_segs(minor_n);
    pt = step_phase(i, nm);
    pp = step_phase(j, nn);
    st = sine_at(pt);
    ct = sine_at((pt + tgv_pkg::DEPTH) % FULL_TURN);
    sp = sine_at(pp);
    cp = sine_at((pp + tgv_pkg::DEPTH) % FULL_TURN);
    ring = (longint'(major_r) <<< 14) + longint'(minor_r) * cp;
    v.px = tgv_pkg::PX_W'(clip(round_q(ring * ct, 28), -131072, 131071));
    v.py = tgv_pkg::PX_W'(clip(round_q(ring * st, 28), -131072, 131071));
    v.pz = tgv_pkg::PZ_W'(clip(round_q(longint'(minor_r) * sp, 14), -65536, 65535));
    v.nx = tgv_pkg::NRM_W'(round_q(cp * ct, 14));
    v.ny = tgv_pkg::NRM_W'(round_q(cp * st, 14));
    v.nz = tgv_pkg::NRM_W'(sp);
    idx = longint'(i) * (nn + 1) + j;
    v.vi = tgv_pkg::IDX_W'(idx);
    v.ni = tgv_pkg::IDX_W'(idx + nn + 1);
    v.quad = (i < nm) && (j < nn);
    v.oor = (i > nm) || (j > nn);
    return v;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at vertex %0d: %s got %0d expected %0d",
             vertices_seen, field, got, want);
    fail_count++;
  endtask

  // receiver
  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else if (rx_hold)
      m_tready <= 1'b0;
    else
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic hold_receiver(int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  // checker and watchdog
  always @(posedge clk) begin
    vertex_t e;
    if (!rst) begin
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
        idle_count <= 0;
      else if (idle_count >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else
        idle_count <= idle_count + 1;
      if (m_tvalid && m_tready) begin
        if (vertex_q.size() == 0) begin
          $display("vertex %0d arrived with nothing expected", vertices_seen);
          fail_count++;
        end else begin
          e = vertex_q.pop_front();
          if ($signed(m_tdata[17:0]) != e.px) report_mismatch("pos_x", $signed(m_tdata[17:0]), e.px);
          if ($signed(m_tdata[35:18]) != e.py) report_mismatch("pos_y", $signed(m_tdata[35:18]), e.py);
          if ($signed(m_tdata[52:36]) != e.pz) report_mismatch("pos_z", $signed(m_tdata[52:36]), e.pz);
          if ($signed(m_tdata[68:53]) != e.nx) report_mismatch("norm_x", $signed(m_tdata[68:53]), e.nx);
          if ($signed(m_tdata[84:69]) != e.ny) report_mismatch("norm_y", $signed(m_tdata[84:69]), e.ny);
          if ($signed(m_tdata[100:85]) != e.nz) report_mismatch("norm_z", $signed(m_tdata[100:85]), e.nz);
          if (m_tdata[121:101] != e.vi) report_mismatch("vertex_index", m_tdata[121:101], e.vi);
          if (m_tdata[142:122] != e.ni) report_mismatch("next_ring_index", m_tdata[142:122], e.ni);
          if (m_tuser[0] != e.quad) report_mismatch("quad_valid", m_tuser[0], e.quad);
          if (m_tuser[1] != e.oor) report_mismatch("out_of_range", m_tuser[1], e.oor);
        end
        vertices_seen <= vertices_seen + 1;
      end
    end
  end

  task automatic send_point(int i, int j);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, 11'(j), 11'(i)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    vertex_q = {vertex_q, predict_vertex(i & 11'h7FF, j & 11'h7FF)};
    points_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [tgv_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= tgv_pkg::RAD_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      tgv_pkg::REG_MAJOR_RADIUS:   major_r = val & 16'hFFFF;
      tgv_pkg::REG_MINOR_RADIUS:   minor_r = val & 16'hFFFF;
      tgv_pkg::REG_MAJOR_SEGMENTS: major_n = val & 11'h7FF;
      tgv_pkg::REG_MINOR_SEGMENTS: minor_n = val & 11'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_torus(int unsigned rr, int unsigned tr, int unsigned nm, int unsigned nn);
    drain();
    write_reg(tgv_pkg::REG_MAJOR_RADIUS, rr);
    write_reg(tgv_pkg::REG_MINOR_RADIUS, tr);
    write_reg(tgv_pkg::REG_MAJOR_SEGMENTS, nm);
    write_reg(tgv_pkg::REG_MINOR_SEGMENTS, nn);
  endtask

  // mostly grid points inside the mesh, some past the seam or anywhere
  task automatic random_points(int count);
    int nm, nn;
    nm = clamp_segs(major_n);
    nn = clamp_segs(minor_n);
    repeat (count) begin
      if ($urandom_range(9) < 8)
        send_point($urandom_range(nm), $urandom_range(nn));
      else
        send_point($urandom_range(2047), $urandom_range(2047));
    end
  endtask

  task automatic test_directed();
    int pts [][2] = '{'{0, 0}, '{32, 16}, '{31, 15}, '{33, 0}, '{0, 17}, '{2047, 2047},
                      '{8, 4}, '{16, 8}, '{24, 12}, '{1024, 1024}, '{32, 0}, '{0, 16}};
    foreach (pts[k]) send_point(pts[k][0], pts[k][1]);
    set_torus(65535, 65535, 1024, 1024);
    foreach (pts[k]) send_point(pts[k][0], pts[k][1]);
    send_point(1023, 1023);
  endtask

  task automatic test_settings();
    int unsigned s [][4] = '{'{0, 0, 0, 0}, '{65535, 65535, 2047, 2047}, '{1, 1, 1, 1},
                             '{65535, 0, 3, 1024}, '{0, 65535, 1024, 3}, '{512, 200, 7, 5}};
    foreach (s[k]) begin
      set_torus(s[k][0], s[k][1], s[k][2], s[k][3]);
      random_points(110);
    end
    set_torus($urandom_range(65535), $urandom_range(65535), 4096 + $urandom_range(1023),
              $urandom_range(2047));
    random_points(110);
  endtask

  task automatic test_backpressure();
    set_torus(300, 80, 24, 12);
    fork
      hold_receiver(300);
    join_none
    random_points(120);
    drain();
    random_points(40);
  endtask

  task automatic test_random();
    set_torus($urandom_range(65535), $urandom_range(65535),
              $urandom_range(1, 1024), $urandom_range(1, 1024));
    random_points(200);
    set_torus($urandom_range(2000), $urandom_range(1000),
              $urandom_range(1, 40), $urandom_range(1, 40));
    random_points(200);
  endtask

  initial begin
    for (int k = 0; k <= tgv_pkg::DEPTH; k++) sine_q[k] = quarter_sine(k);
    major_r = 256; minor_r = 64; major_n = 32; minor_n = 16;
    fail_count = 0; vertices_seen = 0; points_sent = 0; idle_count = 0;
    tx_idle_pct = 8; rx_idle_pct = 80;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_settings();
    tx_idle_pct = 80; rx_idle_pct = 8;
    test_backpressure();
    tx_idle_pct = 0; rx_idle_pct = 0;
    test_random();
    drain();
    $display("%0d grid points sent, %0d vertices checked, across twelve register settings",
             points_sent, vertices_seen);
    $display("including clamped segment counts, extreme radii and a long output stall");
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tgv_pkg.sv
rtl/tgv_phase.sv
rtl/tgv_sine_rom.sv
rtl/tgv_geom.sv
rtl/torus_grid_vertex_generator.sv
verif/tb_top.sv
